FILE: rtl/dfd_pkg.sv
// Package for the delimited frame deframer: phase and result-kind codes,
// configuration register indexes, result and window-control structs.
// No dependencies.
package dfd_pkg;

    localparam int DEF_MAX_DELIM_BYTES = 4;
    localparam logic [2:0] DELIM_LEN_RST = 3'd2;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1514;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_TYPE,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        CFG_DELIM_BYTES,
        CFG_DELIM_LEN,
        CFG_MAX_PAYLOAD
    } t_cfg_idx;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  message_type;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic [15:0] frame_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       shift;
        logic [7:0] rx_byte;
    } t_win_ctl;

endpackage

FILE: rtl/dfd_window.sv
// Delimiter hunting window: recent received bytes and the delimiter compare.
// Depends on dfd_pkg.
module dfd_window #(
    parameter int MAX_DELIM_BYTES = dfd_pkg::DEF_MAX_DELIM_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dfd_pkg::t_win_ctl i_ctl,
    input  logic [31:0]       i_delim_bytes,
    input  logic [2:0]        i_delim_len,
    output logic              o_match
);

    localparam int Win = (MAX_DELIM_BYTES < 4) ? MAX_DELIM_BYTES : 4;
    localparam int CntW = $clog2(Win + 1);

    logic [7:0]      r_win [Win];
    logic [7:0]      n_win [Win];
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic [Win:1]    match_k;
    logic [2:0]      use_len;
    logic            hit;

    always_comb begin
        n_win[0] = i_ctl.rx_byte;
        for (int j = 1; j < Win; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_cnt = (r_cnt == CntW'(Win)) ? r_cnt : r_cnt + 1'b1;

        if (i_delim_len == 3'd0) begin
            use_len = 3'd1;
        end else if (i_delim_len > 3'(Win)) begin
            use_len = 3'(Win);
        end else begin
            use_len = i_delim_len;
        end

        for (int k = 1; k <= Win; k++) begin
            match_k[k] = (n_cnt >= CntW'(k));
            for (int i = 0; i < k; i++) begin
                if (i_delim_bytes[8*i +: 8] != n_win[k-1-i]) begin
                    match_k[k] = 1'b0;
                end
            end
        end

        hit = 1'b0;
        for (int k = 1; k <= Win; k++) begin
            if (use_len == 3'(k)) begin
                hit = match_k[k];
            end
        end
    end

    assign o_match = hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.shift) begin
            r_cnt <= hit ? '0 : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

endmodule

FILE: rtl/dfd_frame_fsm.sv
// Frame parser: phase sequencer, header capture and the result register.
// Depends on dfd_pkg; takes the delimiter match from dfd_window.
module dfd_frame_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    input  logic [7:0]         i_byte,
    output logic               o_take,
    output dfd_pkg::t_win_ctl  o_win,
    input  logic               i_match,
    input  logic [15:0]        i_max_payload,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dfd_pkg::t_result   o_result
);

    dfd_pkg::t_phase  r_phase;
    dfd_pkg::t_phase  n_phase;
    logic [15:0]      r_len;
    logic [15:0]      n_len;
    logic [7:0]       r_type;
    logic [7:0]       n_type;
    logic [15:0]      r_pos;
    logic [15:0]      n_pos;
    logic             r_out_valid;
    dfd_pkg::t_result r_res;
    dfd_pkg::t_result res;
    logic             res_valid;
    logic [15:0]      len_full;
    logic [16:0]      pos_inc;
    logic             fin;
    logic             take;

    always_comb begin
        len_full  = {i_byte, r_len[7:0]};
        pos_inc   = {1'b0, r_pos} + 17'd1;
        fin       = (pos_inc >= {1'b0, r_len});
        res_valid = 1'b0;
        res       = '0;
        n_phase   = r_phase;
        n_len     = r_len;
        n_type    = r_type;
        n_pos     = r_pos;
        case (r_phase)
            dfd_pkg::PH_LEN_LO: begin
                n_len   = {8'h00, i_byte};
                n_phase = dfd_pkg::PH_LEN_HI;
            end
            dfd_pkg::PH_LEN_HI: begin
                n_len = len_full;
                if (len_full > i_max_payload) begin
                    res_valid        = 1'b1;
                    res.kind         = dfd_pkg::KIND_ERROR;
                    res.frame_length = len_full;
                    res.last         = 1'b1;
                    n_phase          = dfd_pkg::PH_HUNT;
                end else begin
                    n_phase = dfd_pkg::PH_TYPE;
                end
            end
            dfd_pkg::PH_TYPE: begin
                n_type = i_byte;
                n_pos  = '0;
                if (r_len == 16'd0) begin
                    res_valid        = 1'b1;
                    res.kind         = dfd_pkg::KIND_EMPTY;
                    res.message_type = i_byte;
                    res.last         = 1'b1;
                    n_phase          = dfd_pkg::PH_HUNT;
                end else begin
                    n_phase = dfd_pkg::PH_PAYLOAD;
                end
            end
            dfd_pkg::PH_PAYLOAD: begin
                res_valid          = 1'b1;
                res.kind           = dfd_pkg::KIND_PAYLOAD;
                res.message_type   = r_type;
                res.payload_byte   = i_byte;
                res.payload_offset = r_pos;
                res.frame_length   = r_len;
                res.last           = fin;
                n_pos              = pos_inc[15:0];
                if (fin) begin
                    n_phase = dfd_pkg::PH_HUNT;
                end
            end
            dfd_pkg::PH_HUNT: begin
                if (i_match) begin
                    n_len   = '0;
                    n_phase = dfd_pkg::PH_LEN_LO;
                end
            end
            default: begin
                n_phase = dfd_pkg::PH_HUNT;
            end
        endcase

        take = i_byte_valid && (!res_valid || !r_out_valid || i_out_ready);
    end

    assign o_take        = take;
    assign o_win.shift   = take && (r_phase == dfd_pkg::PH_HUNT);
    assign o_win.rx_byte = i_byte;
    assign o_out_valid   = r_out_valid;
    assign o_result      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dfd_pkg::PH_HUNT;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
            end
            if (take && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_len  <= n_len;
            r_type <= n_type;
            r_pos  <= n_pos;
        end
        if (take && res_valid) begin
            r_res <= res;
        end
    end

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dfd_pkg::PH_PAYLOAD |-> r_pos < r_len)
        else $error("payload position beyond frame length");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.kind == dfd_pkg::KIND_EMPTY
        |-> r_res.last && r_res.frame_length == 16'd0 && r_res.payload_offset == 16'd0)
        else $error("empty frame result with nonzero fields");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.kind == dfd_pkg::KIND_ERROR
        |-> r_res.last && r_res.message_type == 8'd0 && r_res.payload_byte == 8'd0)
        else $error("length error result with stray fields");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && res_valid |=> r_out_valid)
        else $error("result dropped");

endmodule

FILE: rtl/delimited_frame_deframer.sv
// Top level of the delimited frame deframer: input register, configuration
// registers, hunting window and frame parser.
// Depends on dfd_pkg, dfd_window and dfd_frame_fsm.
//
// Usage: received link bytes enter on the in channel (i_in_valid, o_in_ready,
// i_rx_byte). The block hunts for the configured start delimiter, then reads
// a 16-bit length (low byte first), a type byte and the payload. Each payload
// byte leaves on the out channel (o_out_valid, i_out_ready) with its type,
// offset, frame length and last mark; a zero-length frame gives one empty
// result and a length above max_payload one error result, then hunting.
// Configuration requests on the cfg channel are always taken (o_cfg_ready is
// high); write them only while no byte is in flight.
// A result passes the input register, then the result register. Throughput:
// one byte per cycle while no held result stalls it, set by the update of the
// parser state between the two registers.
// Reset: synchronous, active low; clears the pipeline, returns the parser to
// hunting with an empty window and loads the register reset values.
// Stall: a held result stalls only bytes that would give a result; the input
// register then holds and o_in_ready drops.
module delimited_frame_deframer #(
    parameter int MAX_DELIM_BYTES = dfd_pkg::DEF_MAX_DELIM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_message_type,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_frame_length,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [31:0]       r_delim_bytes;
    logic [2:0]        r_delim_len;
    logic [15:0]       r_max_payload;
    logic              take;
    logic              match;
    dfd_pkg::t_win_ctl win_ctl;
    dfd_pkg::t_result  result;

    assign o_in_ready  = !r_in_valid || take;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes <= '0;
            r_delim_len   <= dfd_pkg::DELIM_LEN_RST;
            r_max_payload <= dfd_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            case (dfd_pkg::t_cfg_idx'(i_cfg_index))
                dfd_pkg::CFG_DELIM_BYTES: r_delim_bytes <= i_cfg_data;
                dfd_pkg::CFG_DELIM_LEN:   r_delim_len   <= i_cfg_data[2:0];
                dfd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    dfd_window #(
        .MAX_DELIM_BYTES(MAX_DELIM_BYTES)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (win_ctl),
        .i_delim_bytes(r_delim_bytes),
        .i_delim_len  (r_delim_len),
        .o_match      (match)
    );

    dfd_frame_fsm u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .o_take       (take),
        .o_win        (win_ctl),
        .i_match      (match),
        .i_max_payload(r_max_payload),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_result_kind    = result.kind;
    assign o_message_type   = result.message_type;
    assign o_payload_byte   = result.payload_byte;
    assign o_payload_offset = result.payload_offset;
    assign o_frame_length   = result.frame_length;
    assign o_last           = result.last;

endmodule

FILE: bench/dfd_frame_checker.sv
// Checker for the delimited frame deframer: watches the cfg, in and out channels,
// keeps its own model of the hunting window and frame parser, and compares results.
// Depends on dfd_pkg.
`timescale 1ns / 100ps

module dfd_frame_checker
    import dfd_pkg::*;
#(
    parameter int MAX_DELIM_BYTES = DEF_MAX_DELIM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_result_kind,
    input  logic [7:0]  i_message_type,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_payload_offset,
    input  logic [15:0] i_frame_length,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] cfg_delim;
    logic [2:0]  cfg_dlen;
    logic [15:0] cfg_max;

    logic [31:0] st_window;
    logic [2:0]  st_count;
    t_phase      st_phase;
    logic [15:0] st_len;
    logic [7:0]  st_type;
    logic [15:0] st_pos;

    t_result     frame_results_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit parse_byte(input logic [7:0] b, output t_result res);
        int          n;
        int          i;
        bit          hit;
        bit          produced;
        logic [16:0] next_pos;
        res      = '0;
        produced = 1'b0;
        case (st_phase)
            PH_LEN_LO: begin
                st_len   = {8'h00, b};
                st_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                st_len = {b, st_len[7:0]};
                if (st_len > cfg_max) begin
                    res.kind         = KIND_ERROR;
                    res.frame_length = st_len;
                    res.last         = 1'b1;
                    st_phase         = PH_HUNT;
                    produced         = 1'b1;
                end else begin
                    st_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                st_type = b;
                st_pos  = 16'd0;
                if (st_len == 16'd0) begin
                    res.kind         = KIND_EMPTY;
                    res.message_type = b;
                    res.last         = 1'b1;
                    st_phase         = PH_HUNT;
                    produced         = 1'b1;
                end else begin
                    st_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                next_pos           = {1'b0, st_pos} + 17'd1;
                res.kind           = KIND_PAYLOAD;
                res.message_type   = st_type;
                res.payload_byte   = b;
                res.payload_offset = st_pos;
                res.frame_length   = st_len;
                res.last           = (next_pos >= {1'b0, st_len});
                st_pos             = next_pos[15:0];
                if (res.last)
                    st_phase = PH_HUNT;
                produced = 1'b1;
            end
            default: begin
                st_phase  = PH_HUNT;
                st_window = {st_window[23:0], b};
                if (st_count < 3'd4)
                    st_count = st_count + 3'd1;
                n = (cfg_dlen == 3'd0) ? 1 : int'(cfg_dlen);
                if (n > MAX_DELIM_BYTES)
                    n = MAX_DELIM_BYTES;
                if (n > 4)
                    n = 4;
                hit = (int'(st_count) >= n);
                for (i = 0; i < n; i++) begin
                    if (cfg_delim[8*i +: 8] != st_window[8*(n-1-i) +: 8])
                        hit = 1'b0;
                end
                if (hit) begin
                    st_window = 32'd0;
                    st_count  = 3'd0;
                    st_len    = 16'd0;
                    st_phase  = PH_LEN_LO;
                end
            end
        endcase
        return produced;
    endfunction

    task automatic note_failure(input string what, input t_result want, input t_result got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t %s: want kind=%0d type=%02h byte=%02h off=%0d len=%0d last=%0b, got kind=%0d type=%02h byte=%02h off=%0d len=%0d last=%0b",
                     $time, what, want.kind, want.message_type, want.payload_byte,
                     want.payload_offset, want.frame_length, want.last,
                     got.kind, got.message_type, got.payload_byte,
                     got.payload_offset, got.frame_length, got.last);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            cfg_delim = 32'd0;
            cfg_dlen  = DELIM_LEN_RST;
            cfg_max   = MAX_PAYLOAD_RST;
            st_window = 32'd0;
            st_count  = 3'd0;
            st_phase  = PH_HUNT;
            st_len    = 16'd0;
            st_type   = 8'd0;
            st_pos    = 16'd0;
            frame_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELIM_BYTES: cfg_delim = i_cfg_data;
                    CFG_DELIM_LEN:   cfg_dlen  = i_cfg_data[2:0];
                    CFG_MAX_PAYLOAD: cfg_max   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.kind           = t_kind'(i_result_kind);
                got.message_type   = i_message_type;
                got.payload_byte   = i_payload_byte;
                got.payload_offset = i_payload_offset;
                got.frame_length   = i_frame_length;
                got.last           = i_last;
                if (frame_results_q.size() == 0) begin
                    note_failure("unexpected result", '0, got);
                end else begin
                    want = frame_results_q.pop_front();
                    if (got.kind !== want.kind || got.message_type !== want.message_type ||
                        got.payload_byte !== want.payload_byte ||
                        got.payload_offset !== want.payload_offset ||
                        got.frame_length !== want.frame_length || got.last !== want.last)
                        note_failure("mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_byte(i_rx_byte, pred))
                    frame_results_q.push_back(pred);
            end
        end
        o_pending = frame_results_q.size();
    end

endmodule

FILE: bench/testbench.sv
// Top of the deframer bench: clock, reset, byte and configuration stimulus,
// receiver stalls, watchdog and verdict.
// Depends on dfd_pkg, delimited_frame_deframer and dfd_frame_checker.
`timescale 1ns / 100ps

module testbench;
    import dfd_pkg::*;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTING_ITEMS = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  message_type;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic [15:0] frame_length;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    int          fail_count;
    int          pending;
    int          sent_items = 0;
    int          out_count = 0;
    bit          random_phase = 1'b0;
    bit          steady = 1'b0;

    logic [31:0] cur_delim = 32'd0;
    int          cur_n = int'(DELIM_LEN_RST);
    logic [15:0] cur_max = MAX_PAYLOAD_RST;

    always #1 clk = ~clk;

    delimited_frame_deframer u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (result_kind),
        .o_message_type   (message_type),
        .o_payload_byte   (payload_byte),
        .o_payload_offset (payload_offset),
        .o_frame_length   (frame_length),
        .o_last           (last),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    dfd_frame_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_kind    (result_kind),
        .i_message_type   (message_type),
        .i_payload_byte   (payload_byte),
        .i_payload_offset (payload_offset),
        .i_frame_length   (frame_length),
        .i_last           (last),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge clk) begin
        if (out_valid && out_ready)
            out_count <= out_count + 1;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        bit         clash;
        int         i;
        do begin
            b     = 8'($urandom_range(0, 255));
            clash = 1'b0;
            for (i = 0; i < cur_n; i++) begin
                if (cur_delim[8*i +: 8] == b)
                    clash = 1'b1;
            end
        end while (clash);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_items++;
    endtask

    // no type byte follows a length the block rejects
    task automatic send_header(input logic [15:0] len, input logic [7:0] typ);
        int i;
        for (i = 0; i < cur_n; i++)
            send_byte(cur_delim[8*i +: 8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len <= cur_max)
            send_byte(typ);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] d, input logic [2:0] code,
                                 input logic [15:0] max);
        logic [31:0] w;
        drain();
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_SPARE_IDX, $urandom());
        write_reg(CFG_DELIM_BYTES, d);
        w      = $urandom();
        w[2:0] = code;
        write_reg(CFG_DELIM_LEN, w);
        w       = $urandom();
        w[15:0] = max;
        write_reg(CFG_MAX_PAYLOAD, w);
        cur_delim = d;
        cur_max   = max;
        cur_n     = (code == 3'd0) ? 1 : int'(code);
        if (cur_n > DEF_MAX_DELIM_BYTES)
            cur_n = DEF_MAX_DELIM_BYTES;
        if (cur_n > 4)
            cur_n = 4;
    endtask

    initial begin : receiver
        int run;
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 16);
            out_ready <= 1'b1;
            repeat (run) @(negedge clk);
            gap = idle_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            // hold off long enough to back up the input side
            if (!held && random_phase && out_count >= 40) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** delimited_frame_deframer: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int          setting;
        int          setting_start;
        int          rand_start;
        int          r;
        int          k;
        int          i;
        int          lim;
        logic [15:0] len;
        logic [15:0] max;
        logic [31:0] d;
        logic [2:0]  code;
        logic [7:0]  fill;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting: two zero delimiter bytes, max 1514
        send_header(16'd2, 8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);

        // one-byte delimiter from a zero length code, nothing but empty frames allowed
        apply_setting(32'hA5C3_3CFF, 3'd0, 16'd0);
        write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
        send_header(16'h0100, 8'h00);
        send_header(16'd0, 8'h81);

        // oversized length code, widest window, max just under full range
        apply_setting(32'h1234_5678, 3'd7, 16'hFFFE);
        send_header(16'hFFFF, 8'h00);
        send_header(16'd1, 8'hC3);
        send_byte(8'h3C);

        random_phase = 1'b1;
        rand_start   = sent_items;
        setting      = 0;
        while (sent_items < rand_start + RANDOM_ITEMS) begin
            d = $urandom();
            case (setting % 4)
                0: begin
                    code = 3'd4;
                    max  = 16'hFFFF;
                end
                1: begin
                    code = 3'd1;
                    max  = 16'd0;
                end
                2: begin
                    code = 3'($urandom_range(5, 7));
                    max  = 16'($urandom_range(1, 8));
                end
                default: begin
                    fill = 8'($urandom_range(0, 255));
                    d    = {4{fill}};
                    code = 3'($urandom_range(0, 7));
                    max  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(4, 40));
                end
            endcase
            apply_setting(d, code, max);
            setting++;
            setting_start = sent_items;
            while (sent_items - setting_start < SETTING_ITEMS &&
                   sent_items < rand_start + RANDOM_ITEMS) begin
                steady = ($urandom_range(0, 7) == 0);
                r      = $urandom_range(0, 99);
                if (r < 72) begin
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                    repeat (k) send_byte(noise_byte());
                    lim = (cur_max > 16'd12) ? 12 : int'(cur_max);
                    if ($urandom_range(0, 9) == 0)
                        lim = (cur_max > 16'd48) ? 48 : int'(cur_max);
                    len = 16'($urandom_range(0, lim));
                    send_header(len, 8'($urandom_range(0, 255)));
                    repeat (len) send_byte(8'($urandom_range(0, 255)));
                end else if (r < 85 && cur_max != 16'hFFFF) begin
                    len = 16'($urandom_range(int'(cur_max) + 1, 65535));
                    send_header(len, 8'h00);
                end else begin
                    // broken delimiter: a proper prefix, then bytes that cannot match
                    k = $urandom_range(0, cur_n - 1);
                    for (i = 0; i < k; i++)
                        send_byte(cur_delim[8*i +: 8]);
                    repeat ($urandom_range(1, 4)) send_byte(noise_byte());
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (6) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** delimited_frame_deframer: PASSED **");
        else
            $display("** delimited_frame_deframer: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dfd_pkg.sv
rtl/dfd_window.sv
rtl/dfd_frame_fsm.sv
rtl/delimited_frame_deframer.sv
bench/dfd_frame_checker.sv
bench/testbench.sv
